@@ design/ddw_pkg.sv @@
// ============================================================================
// ddw_pkg
// Shared constants, types and calendar tables for the date difference block.
// ============================================================================
`default_nettype none

package ddw_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned DIFF_W  = 23;
   localparam int unsigned WDAY_W  = 3;
   localparam int unsigned COUNT_W = 22;   // days since 1900-01-01, max 2958463
   localparam int unsigned DOY_W   = 9;    // zero-based day of year, max 365
   localparam int unsigned YOFF_W  = 13;   // year - 1900
   localparam int unsigned LEAP_W  = 12;   // leap days since base
   localparam int unsigned CENT_W  = 8;    // year / 100

   localparam logic [YEAR_W-1:0] YEAR_BASE = 14'd1900;
   localparam logic [YEAR_W-1:0] YEAR_TOP  = 14'd9999;

   // year / 100 as (year * 5243) >> 19, exact for all 14-bit years
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int unsigned DIV100_SHIFT = 19;
   localparam int unsigned DIV100_PW    = YEAR_W + 13;

   // leap days counted up to year 1899
   localparam logic [LEAP_W-1:0] BASE_LEAPS = 12'd460;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } pipe_load_type;

   // days in a month of a common year, 0 for codes that are no month
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the whole months before month m, common year
   function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] s;
      case (m)
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   // sum of the octal digits; 8 == 1 mod 7, so the sum keeps the residue
   function automatic logic [5:0] octal_sum(input logic [COUNT_W-1:0] c);
      logic [23:0] w;
      logic [5:0]  acc;
      w   = {2'b00, c};
      acc = 6'd0;
      for (int i = 0; i < 8; i++) begin
         acc = acc + {3'b000, w[3*i +: 3]};
      end
      return acc;
   endfunction

   // residue mod 7 of a folded digit sum (at most 56)
   function automatic logic [WDAY_W-1:0] fold_mod7(input logic [5:0] s);
      logic [3:0] t;
      logic [3:0] r;
      t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
      if (t >= 4'd14) begin
         r = t - 4'd14;
      end else if (t >= 4'd7) begin
         r = t - 4'd7;
      end else begin
         r = t;
      end
      return r[WDAY_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/ddw_day_count.sv @@
// ============================================================================
// ddw_day_count
// Three-stage datapath: checks one date and forms its day count since
// 1900-01-01.
// ============================================================================
`default_nettype none

module ddw_day_count (
   input  wire logic                               clock,
   input  wire ddw_pkg::pipe_load_type             load,
   input  wire logic [ddw_pkg::YEAR_W-1:0]         year,
   input  wire logic [ddw_pkg::MONTH_W-1:0]        month,
   input  wire logic [ddw_pkg::DAY_W-1:0]          day,
   output logic [ddw_pkg::COUNT_W-1:0]             count,
   output logic                                    date_ok
);

   // stage 1: year / 100 by reciprocal, range check of the year
   logic [ddw_pkg::DIV100_PW-1:0] prod;
   logic [ddw_pkg::YEAR_W-1:0]    s1_year_ff;
   logic [ddw_pkg::MONTH_W-1:0]   s1_month_ff;
   logic [ddw_pkg::DAY_W-1:0]     s1_day_ff;
   logic [ddw_pkg::CENT_W-1:0]    s1_cent_ff, s1_cent_in;
   logic                          s1_yok_ff, s1_yok_in;

   assign prod       = {13'd0, year} * {{ddw_pkg::YEAR_W{1'b0}}, ddw_pkg::DIV100_MUL};
   assign s1_cent_in = prod[ddw_pkg::DIV100_SHIFT +: ddw_pkg::CENT_W];
   assign s1_yok_in  = (year >= ddw_pkg::YEAR_BASE) && (year <= ddw_pkg::YEAR_TOP);

   always_ff @(posedge clock) begin
      if (load.s1) begin
         s1_year_ff  <= year;
         s1_month_ff <= month;
         s1_day_ff   <= day;
         s1_cent_ff  <= s1_cent_in;
         s1_yok_ff   <= s1_yok_in;
      end
   end

   // stage 2: leap year, leap days so far, month check, day of year
   logic [ddw_pkg::YEAR_W-1:0] cent_x100;
   logic [ddw_pkg::YEAR_W-1:0] rem100;
   logic                       cent_year;
   logic                       leap;
   logic [ddw_pkg::CENT_W-1:0] prev_cent;
   logic [ddw_pkg::YEAR_W-1:0] prev_year;
   logic [ddw_pkg::LEAP_W-1:0] leaps_all;
   logic [ddw_pkg::DAY_W-1:0]  mlen;
   logic                       month_ok;
   logic                       late_leap;

   logic [ddw_pkg::YOFF_W-1:0] s2_yoff_ff, s2_yoff_in;
   logic [ddw_pkg::LEAP_W-1:0] s2_leaps_ff, s2_leaps_in;
   logic [ddw_pkg::DOY_W-1:0]  s2_doy_ff, s2_doy_in;
   logic                       s2_ok_ff, s2_ok_in;

   always_comb begin
      cent_x100 = ddw_pkg::YEAR_W'({6'd0, s1_cent_ff} * 14'd100);
      rem100    = s1_year_ff - cent_x100;
      cent_year = (rem100 == '0);
      // divisible by 400 on century years, by 4 otherwise
      leap      = cent_year ? (s1_cent_ff[1:0] == 2'b00) : (s1_year_ff[1:0] == 2'b00);
      // (year - 1) / 100 drops by one exactly on century years
      prev_cent = cent_year ? (s1_cent_ff - 8'd1) : s1_cent_ff;
      prev_year = s1_year_ff - 14'd1;
      leaps_all = prev_year[ddw_pkg::YEAR_W-1:2] - {4'd0, prev_cent}
                  + {6'd0, prev_cent[ddw_pkg::CENT_W-1:2]};
      s2_leaps_in = leaps_all - ddw_pkg::BASE_LEAPS;
      s2_yoff_in  = ddw_pkg::YOFF_W'(s1_year_ff - ddw_pkg::YEAR_BASE);

      mlen      = ddw_pkg::month_len(s1_month_ff)
                  + {4'd0, (s1_month_ff == ddw_pkg::MONTH_FEB) && leap};
      month_ok  = (s1_month_ff != '0) && (s1_month_ff <= ddw_pkg::MONTH_DEC);
      s2_ok_in  = s1_yok_ff && month_ok && (s1_day_ff != '0) && (s1_day_ff <= mlen);

      late_leap = leap && (s1_month_ff > ddw_pkg::MONTH_FEB);
      s2_doy_in = ddw_pkg::month_start(s1_month_ff) + {8'd0, late_leap}
                  + {4'd0, s1_day_ff} - 9'd1;
   end

   always_ff @(posedge clock) begin
      if (load.s2) begin
         s2_yoff_ff  <= s2_yoff_in;
         s2_leaps_ff <= s2_leaps_in;
         s2_doy_ff   <= s2_doy_in;
         s2_ok_ff    <= s2_ok_in;
      end
   end

   // stage 3: 365 * years + leap days + day of year
   logic [ddw_pkg::COUNT_W-1:0] s3_count_ff, s3_count_in;
   logic                        s3_ok_ff;

   assign s3_count_in = ddw_pkg::COUNT_W'({9'd0, s2_yoff_ff} * 22'd365)
                        + {10'd0, s2_leaps_ff} + {13'd0, s2_doy_ff};

   always_ff @(posedge clock) begin
      if (load.s3) begin
         s3_count_ff <= s3_count_in;
         s3_ok_ff    <= s2_ok_ff;
      end
   end

   assign count   = s3_count_ff;
   assign date_ok = s3_ok_ff;

endmodule

`default_nettype wire

@@ design/ddw_result.sv @@
// ============================================================================
// ddw_result
// Two-stage tail: difference of the day counts, weekdays by mod-7 folding,
// error masking and the result register.
// ============================================================================
`default_nettype none

module ddw_result (
   input  wire logic                               clock,
   input  wire ddw_pkg::pipe_load_type             load,
   input  wire logic [ddw_pkg::COUNT_W-1:0]        first_count,
   input  wire logic                               first_ok,
   input  wire logic [ddw_pkg::COUNT_W-1:0]        second_count,
   input  wire logic                               second_ok,
   output logic signed [ddw_pkg::DIFF_W-1:0]       day_difference,
   output logic [ddw_pkg::WDAY_W-1:0]              first_weekday,
   output logic [ddw_pkg::WDAY_W-1:0]              second_weekday,
   output logic                                    date_error
);

   // stage 4: subtract, first digit fold
   logic [ddw_pkg::DIFF_W-1:0] s4_diff_ff, s4_diff_in;
   logic [5:0]                 s4_fsum_ff, s4_ssum_ff;
   logic                       s4_err_ff;

   assign s4_diff_in = {1'b0, second_count} - {1'b0, first_count};

   always_ff @(posedge clock) begin
      if (load.s4) begin
         s4_diff_ff <= s4_diff_in;
         s4_fsum_ff <= ddw_pkg::octal_sum(first_count);
         s4_ssum_ff <= ddw_pkg::octal_sum(second_count);
         s4_err_ff  <= !(first_ok && second_ok);
      end
   end

   // stage 5: final fold; difference and weekdays zero on a bad date
   logic signed [ddw_pkg::DIFF_W-1:0] s5_diff_ff, s5_diff_in;
   logic [ddw_pkg::WDAY_W-1:0]        s5_fwd_ff, s5_fwd_in;
   logic [ddw_pkg::WDAY_W-1:0]        s5_swd_ff, s5_swd_in;
   logic                              s5_err_ff;

   always_comb begin
      s5_diff_in = s4_err_ff ? '0 : $signed(s4_diff_ff);
      s5_fwd_in  = s4_err_ff ? '0 : ddw_pkg::fold_mod7(s4_fsum_ff) + 3'd1;
      s5_swd_in  = s4_err_ff ? '0 : ddw_pkg::fold_mod7(s4_ssum_ff) + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (load.s5) begin
         s5_diff_ff <= s5_diff_in;
         s5_fwd_ff  <= s5_fwd_in;
         s5_swd_ff  <= s5_swd_in;
         s5_err_ff  <= s4_err_ff;
      end
   end

   assign day_difference = s5_diff_ff;
   assign first_weekday  = s5_fwd_ff;
   assign second_weekday = s5_swd_ff;
   assign date_error     = s5_err_ff;

endmodule

`default_nettype wire

@@ design/date_difference_and_weekday.sv @@
// Requests pass through the register stages s1..s5 to the response.
// Throughput: one date pair per cycle unless the response stalls; five
// register stages, each advancing when it is empty or the next advances.
// Reset: synchronous, active high; clears the stage valid bits only, so the
// pipeline comes up empty. The datapath registers are not reset.
// ============================================================================
// date_difference_and_weekday
// Signed day difference between two Gregorian dates (1900..9999) and the
// weekday of each (1 = Monday .. 7 = Sunday), with an error flag for bad dates.
// ============================================================================
`default_nettype none

module date_difference_and_weekday (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [ddw_pkg::YEAR_W-1:0]         req_first_year,
   input  wire logic [ddw_pkg::MONTH_W-1:0]        req_first_month,
   input  wire logic [ddw_pkg::DAY_W-1:0]          req_first_day,
   input  wire logic [ddw_pkg::YEAR_W-1:0]         req_second_year,
   input  wire logic [ddw_pkg::MONTH_W-1:0]        req_second_month,
   input  wire logic [ddw_pkg::DAY_W-1:0]          req_second_day,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [ddw_pkg::DIFF_W-1:0]       rsp_day_difference,
   output logic [ddw_pkg::WDAY_W-1:0]              rsp_first_weekday,
   output logic [ddw_pkg::WDAY_W-1:0]              rsp_second_weekday,
   output logic                                    rsp_date_error
);

   // Stage map
   //   s1: year / 100 by reciprocal multiply, year range check
   //   s2: leap year, leap days since 1900, month/day check, day of year
   //   s3: day count = 365 * (year - 1900) + leap days + day of year
   //   s4: difference of the counts, octal digit sums for mod 7
   //   s5: final mod-7 fold, zeroing on error; this is the response register
   // Weekday: 1900-01-01 was a Monday, so weekday = count mod 7 + 1.

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   ddw_pkg::pipe_load_type load;

   // A stage takes new data when it is empty or its content moves on.
   // The last stage holds while a response is stalled.
   always_comb begin
      rdy5 = !v5_ff || !rsp_stall;
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;

      load.s1 = rdy1;
      load.s2 = rdy2;
      load.s3 = rdy3;
      load.s4 = rdy4;
      load.s5 = rdy5;

      v1_in = rdy1 ? req_valid : v1_ff;
      v2_in = rdy2 ? v1_ff     : v2_ff;
      v3_in = rdy3 ? v2_ff     : v3_ff;
      v4_in = rdy4 ? v3_ff     : v4_ff;
      v5_in = rdy5 ? v4_ff     : v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   assign req_stall = !rdy1;
   assign rsp_valid = v5_ff;

   // one day-count datapath per date, stages s1..s3
   logic [ddw_pkg::COUNT_W-1:0] first_count, second_count;
   logic                        first_ok, second_ok;

   ddw_day_count u_first_count (
      .clock   (clock),
      .load    (load),
      .year    (req_first_year),
      .month   (req_first_month),
      .day     (req_first_day),
      .count   (first_count),
      .date_ok (first_ok)
   );

   ddw_day_count u_second_count (
      .clock   (clock),
      .load    (load),
      .year    (req_second_year),
      .month   (req_second_month),
      .day     (req_second_day),
      .count   (second_count),
      .date_ok (second_ok)
   );

   // stages s4..s5 and the response register
   ddw_result u_result (
      .clock          (clock),
      .load           (load),
      .first_count    (first_count),
      .first_ok       (first_ok),
      .second_count   (second_count),
      .second_ok      (second_ok),
      .day_difference (rsp_day_difference),
      .first_weekday  (rsp_first_weekday),
      .second_weekday (rsp_second_weekday),
      .date_error     (rsp_date_error)
   );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ============================================================================
// testbench
// Checks the date difference and weekday block against a predictor in the
// bench: directed calendar corners first, then mostly valid random date
// pairs mixed with malformed ones, under random gaps and stalls.
// ============================================================================

module testbench;

   // one request transfer: two calendar dates
   typedef struct {
      logic [ddw_pkg::YEAR_W-1:0]  first_year;
      logic [ddw_pkg::MONTH_W-1:0] first_month;
      logic [ddw_pkg::DAY_W-1:0]   first_day;
      logic [ddw_pkg::YEAR_W-1:0]  second_year;
      logic [ddw_pkg::MONTH_W-1:0] second_month;
      logic [ddw_pkg::DAY_W-1:0]   second_day;
   } date_pair_type;

   // one response transfer
   typedef struct {
      logic signed [ddw_pkg::DIFF_W-1:0] day_difference;
      logic [ddw_pkg::WDAY_W-1:0]        first_weekday;
      logic [ddw_pkg::WDAY_W-1:0]        second_weekday;
      logic                              date_error;
   } span_result_type;

   localparam int IDLE_LIMIT  = 2000;   // cycles with no transfer on either side
   localparam int HOLD_CYCLES = 120;    // long receiver hold-off
   localparam int DRAIN_WAIT  = 20;     // pipeline is 5 deep, this is plenty
   localparam int N_RANDOM    = 530;

   // common-year month lengths, index 0 is no month
   localparam int unsigned MONTH_DAYS [13] =
      '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid        = 1'b0;
   logic                              req_stall;
   logic [ddw_pkg::YEAR_W-1:0]        req_first_year   = '0;
   logic [ddw_pkg::MONTH_W-1:0]       req_first_month  = '0;
   logic [ddw_pkg::DAY_W-1:0]         req_first_day    = '0;
   logic [ddw_pkg::YEAR_W-1:0]        req_second_year  = '0;
   logic [ddw_pkg::MONTH_W-1:0]       req_second_month = '0;
   logic [ddw_pkg::DAY_W-1:0]         req_second_day   = '0;

   logic                              rsp_valid;
   logic                              rsp_stall        = 1'b0;
   logic signed [ddw_pkg::DIFF_W-1:0] rsp_day_difference;
   logic [ddw_pkg::WDAY_W-1:0]        rsp_first_weekday;
   logic [ddw_pkg::WDAY_W-1:0]        rsp_second_weekday;
   logic                              rsp_date_error;

   date_pair_type   pending_pairs[$];    // stimulus not yet offered
   span_result_type expected_spans[$];   // predictions awaiting a response

   date_pair_type   offered;
   span_result_type predicted;
   span_result_type seen;
   span_result_type want;

   int  error_count  = 0;
   int  req_count    = 0;
   int  rsp_count    = 0;
   int  bad_count    = 0;
   int  holds_done   = 0;
   int  gap_left     = 0;
   int  stall_left   = 0;
   int  hold_left    = 0;
   int  idle_cycles  = 0;
   logic hold_on     = 1'b0;    // registered view of the hold for the driver
   logic calm        = 1'b0;    // no idling on either side while set

   date_difference_and_weekday uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_year     (req_first_year),
      .req_first_month    (req_first_month),
      .req_first_day      (req_first_day),
      .req_second_year    (req_second_year),
      .req_second_month   (req_second_month),
      .req_second_day     (req_second_day),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_day_difference (rsp_day_difference),
      .rsp_first_weekday  (rsp_first_weekday),
      .rsp_second_weekday (rsp_second_weekday),
      .rsp_date_error     (rsp_date_error)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Calendar predictor
   // ------------------------------------------------------------------

   // Gregorian rule: every 4th year, except centuries not divisible by 400
   function automatic logic is_leap_year(input int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   // leap years in 1..n
   function automatic int unsigned leaps_through(input int unsigned n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
      int unsigned len;
      len = (m <= ddw_pkg::MONTH_DEC) ? MONTH_DAYS[m] : 0;
      if (m == ddw_pkg::MONTH_FEB && is_leap_year(y)) begin
         len = len + 1;
      end
      return len;
   endfunction

   // days since 1900-01-01; returns 0 for a date outside the calendar
   function automatic logic days_since_base(input logic [ddw_pkg::YEAR_W-1:0] y,
                                            input logic [ddw_pkg::MONTH_W-1:0] m,
                                            input logic [ddw_pkg::DAY_W-1:0] d,
                                            output int unsigned count);
      int unsigned base;
      count = 0;
      base  = ddw_pkg::YEAR_BASE;
      if (y < ddw_pkg::YEAR_BASE || y > ddw_pkg::YEAR_TOP || m == 0
          || m > ddw_pkg::MONTH_DEC || d == 0) begin
         return 1'b0;
      end
      if (d > month_days(y, m)) begin
         return 1'b0;
      end
      count = 365 * (y - base) + leaps_through(y - 1) - leaps_through(base - 1);
      for (int mm = 1; mm < m; mm++) begin
         count = count + month_days(y, mm);
      end
      count = count + d - 1;
      return 1'b1;
   endfunction

   function automatic span_result_type predict_span(input date_pair_type p);
      span_result_type r;
      int unsigned     c1, c2;
      logic            ok1, ok2;
      int              delta;
      ok1 = days_since_base(p.first_year, p.first_month, p.first_day, c1);
      ok2 = days_since_base(p.second_year, p.second_month, p.second_day, c2);
      r.day_difference = '0;
      r.first_weekday  = '0;
      r.second_weekday = '0;
      r.date_error     = 1'b1;
      if (ok1 && ok2) begin
         // 1900-01-01 was a Monday, so the count mod 7 gives Monday = 1
         delta            = int'(c2) - int'(c1);
         r.day_difference = delta[ddw_pkg::DIFF_W-1:0];
         r.first_weekday  = ddw_pkg::WDAY_W'(c1 % 7 + 1);
         r.second_weekday = ddw_pkg::WDAY_W'(c2 % 7 + 1);
         r.date_error     = 1'b0;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // years weighted toward leap and century corners
   function automatic int unsigned pick_year();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(ddw_pkg::YEAR_BASE, ddw_pkg::YEAR_TOP);
      if (r < 70) return 4 * $urandom_range(475, 2499);
      if (r < 85) return 100 * $urandom_range(19, 99);
      if (r < 93) return $urandom_range(ddw_pkg::YEAR_BASE, ddw_pkg::YEAR_BASE + 10);
      return $urandom_range(ddw_pkg::YEAR_TOP - 10, ddw_pkg::YEAR_TOP);
   endfunction

   task automatic pick_date(output logic [ddw_pkg::YEAR_W-1:0] y,
                            output logic [ddw_pkg::MONTH_W-1:0] m,
                            output logic [ddw_pkg::DAY_W-1:0] d);
      int r;
      int unsigned len;
      r = $urandom_range(0, 99);
      y = ddw_pkg::YEAR_W'(pick_year());
      m = ddw_pkg::MONTH_W'($urandom_range(1, 12));
      len = month_days(y, m);
      if (r < 88) begin
         // well formed; favor month ends
         d = ($urandom_range(0, 3) == 0) ? ddw_pkg::DAY_W'(len)
                                         : ddw_pkg::DAY_W'($urandom_range(1, len));
      end else if (r < 93) begin
         d = (len < 31) ? ddw_pkg::DAY_W'($urandom_range(len + 1, 31)) : '0;
      end else if (r < 96) begin
         m = ($urandom_range(0, 3) == 0) ? '0 : ddw_pkg::MONTH_W'($urandom_range(13, 15));
         d = ddw_pkg::DAY_W'($urandom_range(1, 28));
      end else begin
         // raw noise over every bit
         y = ddw_pkg::YEAR_W'($urandom_range(0, (1 << ddw_pkg::YEAR_W) - 1));
         m = ddw_pkg::MONTH_W'($urandom_range(0, (1 << ddw_pkg::MONTH_W) - 1));
         d = ddw_pkg::DAY_W'($urandom_range(0, (1 << ddw_pkg::DAY_W) - 1));
      end
   endtask

   task automatic add_pair(input int y1, input int m1, input int d1,
                           input int y2, input int m2, input int d2);
      date_pair_type p;
      p.first_year   = ddw_pkg::YEAR_W'(y1);
      p.first_month  = ddw_pkg::MONTH_W'(m1);
      p.first_day    = ddw_pkg::DAY_W'(d1);
      p.second_year  = ddw_pkg::YEAR_W'(y2);
      p.second_month = ddw_pkg::MONTH_W'(m2);
      p.second_day   = ddw_pkg::DAY_W'(d2);
      pending_pairs = {pending_pairs, p};
   endtask

   task automatic report_mismatch(input string field, input int got, input int exp_val);
      $display("mismatch: response %0d field %s got %0d expected %0d",
               rsp_count, field, got, exp_val);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Driver: offers pending pairs, holds the payload while stalled
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted = predict_span(offered);
            expected_spans = {expected_spans, predicted};
            if (predicted.date_error) bad_count++;
            req_count++;
         end
         calm <= ((req_count / 64) % 4) == 1;
         if (!req_valid || !req_stall) begin
            if (gap_left != 0 && !hold_on && !calm) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
               offered = pending_pairs.pop_front();
               req_first_year   <= offered.first_year;
               req_first_month  <= offered.first_month;
               req_first_day    <= offered.first_day;
               req_second_year  <= offered.second_year;
               req_second_month <= offered.second_month;
               req_second_day   <= offered.second_day;
               req_valid        <= 1'b1;
               gap_left = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each response transfer and drives the stall
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.day_difference = rsp_day_difference;
            seen.first_weekday  = rsp_first_weekday;
            seen.second_weekday = rsp_second_weekday;
            seen.date_error     = rsp_date_error;
            if (expected_spans.size() == 0) begin
               report_mismatch("unexpected_response", 1, 0);
            end else begin
               want = expected_spans.pop_front();
               if (seen.day_difference !== want.day_difference)
                  report_mismatch("day_difference", int'(seen.day_difference),
                                  int'(want.day_difference));
               if (seen.first_weekday !== want.first_weekday)
                  report_mismatch("first_weekday", seen.first_weekday, want.first_weekday);
               if (seen.second_weekday !== want.second_weekday)
                  report_mismatch("second_weekday", seen.second_weekday, want.second_weekday);
               if (seen.date_error !== want.date_error)
                  report_mismatch("date_error", seen.date_error, want.date_error);
            end
            rsp_count++;
            // long hold-offs: the sender keeps offering, so the pipe backs up
            if (rsp_count == 200 || rsp_count == 450) begin
               hold_left = HOLD_CYCLES;
               holds_done++;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= 1'b0;
         end
         hold_on <= (hold_left != 0);
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without any transfer ends the run
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("testbench: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: directed corners, random pairs, drain, verdict
   // ------------------------------------------------------------------
   initial begin
      date_pair_type p;
      // identical base dates, then the full span both ways
      add_pair(1900, 1, 1, 1900, 1, 1);
      add_pair(1900, 1, 1, 9999, 12, 31);
      add_pair(9999, 12, 31, 1900, 1, 1);
      // leap rule corners: 400-year leap, century non-leap, plain leap
      add_pair(2000, 2, 29, 1900, 2, 28);
      add_pair(1900, 2, 29, 1901, 1, 1);
      add_pair(2100, 2, 29, 2024, 2, 29);
      add_pair(2024, 2, 29, 2400, 2, 29);
      add_pair(1999, 12, 31, 2000, 1, 1);
      add_pair(1904, 2, 29, 1903, 3, 1);
      add_pair(9999, 2, 28, 9996, 2, 29);
      add_pair(2023, 6, 30, 2023, 7, 31);
      // bad month codes
      add_pair(1900, 0, 1, 1900, 1, 1);
      add_pair(1900, 1, 1, 2000, 13, 1);
      add_pair(2000, 15, 31, 2000, 1, 1);
      // bad days
      add_pair(2000, 1, 0, 2000, 1, 1);
      add_pair(2000, 4, 31, 2000, 5, 1);
      add_pair(2000, 1, 1, 2001, 2, 29);
      // years out of range and raw field extremes
      add_pair(1899, 12, 31, 1900, 1, 1);
      add_pair(10000, 1, 1, 9999, 12, 31);
      add_pair(16383, 15, 31, 16383, 15, 31);
      add_pair(0, 0, 0, 0, 0, 0);

      repeat (N_RANDOM) begin
         pick_date(p.first_year, p.first_month, p.first_day);
         pick_date(p.second_year, p.second_month, p.second_day);
         pending_pairs = {pending_pairs, p};
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || req_valid || expected_spans.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      while (expected_spans.size() != 0) begin
         void'(expected_spans.pop_front());
         report_mismatch("missing_response", 0, 1);
      end

      $display("covered %0d date pairs (%0d with a bad date), %0d responses checked",
               req_count, bad_count, rsp_count);
      $display("directed calendar corners plus random dates, %0d long receiver hold-offs",
               holds_done);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
